[src/dad_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dad_pkg: shared types, constants and functions for the date adder
// Holds the sequencer states, field widths, the month length table and the
// small weekday reduction used by the month walk.
// ----------------------------------------------------------------------------
package dad_pkg;

	// Field widths
	localparam int WEEKDAY_W = 3;
	localparam int DAY_W     = 5;
	localparam int MONTH_W   = 4;
	localparam int YEAR_W    = 14;
	localparam int ADD_W     = 16;

	// Day counter width actually used from days_to_add
	localparam int DAYS_WIDTH = 16;

	// Reciprocal of 100 for year values below 2**YEAR_W
	localparam int RECIP_SHIFT = 19;
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam int CENT_W = 8;

	// Calendar codes
	localparam logic [MONTH_W-1:0]   MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0]   MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0]   MONTH_APR = 4'd4;
	localparam logic [MONTH_W-1:0]   MONTH_JUN = 4'd6;
	localparam logic [MONTH_W-1:0]   MONTH_SEP = 4'd9;
	localparam logic [MONTH_W-1:0]   MONTH_NOV = 4'd11;
	localparam logic [MONTH_W-1:0]   MONTH_DEC = 4'd12;
	localparam logic [WEEKDAY_W-1:0] WEEKDAY_SAT = 3'd7;
	localparam logic [5:0]           WEEK_LEN = 6'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEAP,
		ST_CLAMP,
		ST_WALK,
		ST_DONE
	} dad_state_t;

	// Length of a month, February taking the leap flag
	function automatic logic [DAY_W-1:0] month_days(
		input logic [MONTH_W-1:0] mon,
		input logic               leap
	);
		logic [DAY_W-1:0] n;
		case (mon) inside
			MONTH_FEB: n = leap ? 5'd29 : 5'd28;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: n = 5'd30;
			default: n = 5'd31;
		endcase
		return n;
	endfunction

	// Reduce a small value modulo seven
	function automatic logic [WEEKDAY_W-1:0] mod7(input logic [5:0] x);
		logic [5:0] v;
		v = x;
		for (int i = 0; i < 5; i++) begin
			if (v >= WEEK_LEN)
				v = v - WEEK_LEN;
		end
		return v[WEEKDAY_W-1:0];
	endfunction

endpackage

[src/date_add_days.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_add_days: add a day count to a Gregorian date
// Walks the date forward one month per cycle and tracks the weekday.
// ----------------------------------------------------------------------------
// One transaction at a time: a date is taken, the block is busy until its
// result has been taken. The states ST_LEAP and ST_CLAMP come first, then
// the month walk crosses one month per cycle, one subtract and compare
// against the month length, until a count of up to 65535 days ends inside
// a month. The start day is clamped into its month (zero becomes 1, past
// the end becomes the last day), a month outside 1..12 is taken as December,
// the year wraps at 14 bits, and the weekday is reported 1..7 for
// Sunday..Saturday.
module date_add_days import dad_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [WEEKDAY_W-1:0] start_weekday,
	input  logic [DAY_W-1:0]     start_day,
	input  logic [MONTH_W-1:0]   start_month,
	input  logic [YEAR_W-1:0]    start_year,
	input  logic [ADD_W-1:0]     days_to_add,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [WEEKDAY_W-1:0] end_weekday,
	output logic [DAY_W-1:0]     end_day,
	output logic [MONTH_W-1:0]   end_month,
	output logic [YEAR_W-1:0]    end_year
);

	dad_state_t state_q, state_d;

	logic [WEEKDAY_W-1:0]  wd_q;
	logic [DAY_W-1:0]      day_q;
	logic [MONTH_W-1:0]    mon_q;
	logic [YEAR_W-1:0]     yr_q;
	logic [DAYS_WIDTH-1:0] add_q;
	logic                  leap_q;

	logic [DAY_W-1:0]      len;
	logic [DAY_W-1:0]      rem;
	logic [5:0]            rem_inc;
	logic                  step;
	logic                  in_fire;

	// Leap flag of the current year, registered from yr_q
	dad_leap_unit u_leap (
		.clk    (clk),
		.year   (yr_q),
		.leap_q (leap_q)
	);

	// Shared compare: does the remaining count run past this month
	assign len     = month_days(mon_q, leap_q);
	assign rem     = len - day_q;
	assign rem_inc = 6'(rem) + 6'd1;
	assign step    = add_q > DAYS_WIDTH'(rem);
	assign in_fire = in_valid && in_ready;

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = ST_LEAP;
			end
			ST_LEAP:  state_d = ST_CLAMP;
			ST_CLAMP: state_d = ST_WALK;
			ST_WALK: begin
				if (add_q == '0 || !step)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				out_valid = 1'b1;
				if (out_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Date registers: load, clamp, then advance one month per cycle
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					wd_q  <= mod7({3'd0, start_weekday});
					day_q <= start_day;
					mon_q <= (start_month == '0 || start_month > MONTH_DEC) ?
						MONTH_DEC : start_month;
					yr_q  <= start_year;
					add_q <= DAYS_WIDTH'(days_to_add);
				end
			end
			ST_CLAMP: begin
				if (day_q == '0)
					day_q <= DAY_W'(1);
				else if (day_q > len)
					day_q <= len;
			end
			ST_WALK: begin
				if (add_q != '0) begin
					if (step) begin
						// Cross into the first day of the next month
						add_q <= add_q - DAYS_WIDTH'(rem_inc);
						wd_q  <= mod7(6'(wd_q) + rem_inc);
						day_q <= DAY_W'(1);
						if (mon_q == MONTH_DEC) begin
							mon_q <= MONTH_JAN;
							yr_q  <= yr_q + YEAR_W'(1);
						end else begin
							mon_q <= mon_q + MONTH_W'(1);
						end
					end else begin
						// Finish inside this month
						day_q <= day_q + add_q[DAY_W-1:0];
						wd_q  <= mod7(6'(wd_q) + 6'(add_q[DAY_W-1:0]));
						add_q <= '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Result ports
	assign end_weekday = (wd_q == '0) ? WEEKDAY_SAT : wd_q;
	assign end_day     = day_q;
	assign end_month   = mon_q;
	assign end_year    = yr_q;

	// Busy after taking a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a transaction is in flight");

	// Never both sides open at once
	a_sides_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is pending");

	// An exhausted count finishes the walk
	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) && (add_q == '0) |=> out_valid)
		else $error("walk did not end on an empty count");

	// Result date stays in range
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (end_day != '0) && (end_month != '0) && (end_month <= MONTH_DEC)
			&& (end_weekday != '0))
		else $error("result date out of range");

endmodule

[src/dad_leap_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dad_leap_unit: registered Gregorian leap year flag
// Applies the 4/100/400 rule to a 14-bit year; the century quotient comes
// from a reciprocal multiply, and the flag is valid in the cycle after the year.
// ----------------------------------------------------------------------------
module dad_leap_unit import dad_pkg::*; (
	input  logic              clk,
	input  logic [YEAR_W-1:0] year,
	output logic              leap_q
);

	logic [YEAR_W+12:0] prod;
	logic [CENT_W-1:0]  cent;
	logic [YEAR_W-1:0]  cent_x100;
	logic               div100;
	logic               leap;

	// Split off the century and check for an exact multiple of 100
	assign prod      = (YEAR_W + 13)'(year) * (YEAR_W + 13)'(RECIP_100);
	assign cent      = prod[RECIP_SHIFT +: CENT_W];
	assign cent_x100 = (YEAR_W'(cent) << 6) + (YEAR_W'(cent) << 5) + (YEAR_W'(cent) << 2);
	assign div100    = (cent_x100 == year);
	assign leap      = (year[1:0] == 2'd0) && (!div100 || (cent[1:0] == 2'd0));

	// Hold the flag for the next cycle
	always_ff @(posedge clk) begin
		leap_q <= leap;
	end

endmodule
